FILE: rtl/link_prr_update_and_rank_macros.svh
// Assertion shorthands shared by the checking code of this block.
`ifndef LINK_PRR_UPDATE_AND_RANK_MACROS_SVH
`define LINK_PRR_UPDATE_AND_RANK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRR_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPRR_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lprr_pkg.sv
package lprr_pkg;

  localparam logic [1:0] ST_ACK   = 2'd0;
  localparam logic [1:0] ST_NOACK = 2'd1;

  // ceil(2^30 / 100); x * RECIP >> 30 equals x / 100 for x below 14e6.
  localparam logic [23:0] RECIP      = 24'd10737419;
  localparam logic [46:0] BLEND_UNIT = 47'(65535) * 47'(RECIP);
  localparam logic [6:0]  ALPHA_MAX  = 7'd100;

  typedef struct packed {
    logic [15:0] rate;
    logic [1:0]  status;
    logic [15:0] prank;
  } item_t;

  typedef struct packed {
    logic [15:0] rate;
    logic        changed;
    logic [16:0] loss;
    logic [15:0] prank;
  } loss_t;

  typedef struct packed {
    logic [15:0] rate;
    logic        changed;
    logic [32:0] prod;
    logic [15:0] floor_rank;
  } rank_t;

  function automatic logic [6:0] alpha_clip_f(input logic [6:0] a);
    return (a > ALPHA_MAX) ? ALPHA_MAX : a;
  endfunction

  // Alpha pre-scaled by the reciprocal of one hundred.
  function automatic logic [30:0] alpha_k_f(input logic [6:0] a);
    return 31'(alpha_clip_f(a)) * 31'(RECIP);
  endfunction

  // 65535 * (100 - alpha), pre-scaled by the reciprocal of one hundred.
  function automatic logic [46:0] blend_k_f(input logic [6:0] a);
    return 47'(ALPHA_MAX - alpha_clip_f(a)) * BLEND_UNIT;
  endfunction

endpackage

FILE: rtl/lprr_decay_cell.sv
module lprr_decay_cell #(
  parameter int IDX = 1,
  parameter int TW  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  lprr_pkg::item_t     item_i,
  input  logic [TW-1:0]       tries_i,
  input  logic [30:0]         alpha_k_i,
  output logic                valid_o,
  output lprr_pkg::item_t     item_o,
  output logic [TW-1:0]       tries_o
);
  import lprr_pkg::*;

  logic        valid_q;
  item_t       item_q, item_d;
  logic [TW-1:0] tries_q;
  logic [46:0] prod;
  logic        apply;

  // One failed attempt scales the rate by alpha / 100.
  assign apply = (item_i.status == ST_ACK || item_i.status == ST_NOACK) &&
                 (tries_i > TW'(IDX));
  assign prod  = 47'(item_i.rate) * 47'(alpha_k_i);

  always_comb begin
    item_d = item_i;
    if (apply) begin
      item_d.rate = prod[45:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q  <= item_d;
      tries_q <= tries_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign tries_o = tries_q;

endmodule

FILE: rtl/lprr_final_cell.sv
module lprr_final_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  lprr_pkg::item_t item_i,
  input  logic [30:0]     alpha_k_i,
  input  logic [46:0]     blend_k_i,
  output logic            valid_o,
  output lprr_pkg::loss_t data_o
);
  import lprr_pkg::*;

  logic        valid_q;
  loss_t       data_q, data_d;
  logic [46:0] prod;
  logic [47:0] sum;
  logic        changed;

  assign changed = (item_i.status == ST_ACK) || (item_i.status == ST_NOACK);
  assign prod    = 47'(item_i.rate) * 47'(alpha_k_i);
  // An acknowledged frame blends toward full reception; a lost one decays.
  assign sum     = {1'b0, prod} +
                   ((item_i.status == ST_ACK) ? {1'b0, blend_k_i} : 48'd0);

  always_comb begin
    data_d.rate    = changed ? sum[45:30] : item_i.rate;
    data_d.changed = changed;
    data_d.loss    = 17'h10000;
    data_d.prank   = item_i.prank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/lprr_loss_cell.sv
module lprr_loss_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  lprr_pkg::loss_t data_i,
  output logic            valid_o,
  output lprr_pkg::loss_t data_o
);
  import lprr_pkg::*;

  logic        valid_q;
  loss_t       data_q, data_d;
  logic [16:0] link_loss;
  logic [33:0] prod;

  // One 1.16 step of raising the link loss to a power, truncating.
  assign link_loss = 17'h10000 - {1'b0, data_i.rate};
  assign prod      = 34'(data_i.loss) * 34'(link_loss);

  always_comb begin
    data_d      = data_i;
    data_d.loss = prod[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/lprr_rank_cell.sv
module lprr_rank_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  lprr_pkg::loss_t data_i,
  input  logic [15:0]     min_rank_inc_i,
  output logic            valid_o,
  output lprr_pkg::rank_t data_o
);
  import lprr_pkg::*;

  logic        valid_q;
  rank_t       data_q, data_d;
  logic [16:0] parent_ratio;
  logic [15:0] link_ratio;
  logic [16:0] floor_sum;

  // A loss of exactly one (rate zero) leaves no delivery at all.
  assign link_ratio   = data_i.loss[16] ? 16'd0 : (16'hFFFF - data_i.loss[15:0]);
  assign parent_ratio = 17'h10000 - {1'b0, data_i.prank};
  assign floor_sum    = {1'b0, data_i.prank} + {1'b0, min_rank_inc_i};

  always_comb begin
    data_d.rate       = data_i.rate;
    data_d.changed    = data_i.changed;
    data_d.prod       = 33'(parent_ratio) * 33'(link_ratio);
    data_d.floor_rank = floor_sum[16] ? 16'hFFFF : floor_sum[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/link_prr_update_and_rank.sv
// Link reception-rate update and path rank.
//
// The input channel (in_valid_i / in_stall_o) carries one transmission report
// per item: the stored rate, the status, the attempt count and the rank the
// neighbor advertises. The output channel (out_valid_o / out_stall_i) returns
// one item per report with the updated rate, a flag telling whether the rate
// was touched, and the rank through that neighbor.
// The datapath is a row of cells that pass each item along: MAX_ATTEMPTS - 1
// decay cells, one cell for the last attempt, four cells that raise the link
// loss to the fourth power, one cell for the path product and the output
// register. Unless the receiver stalls, the row takes a new item in every
// cycle, so throughput is one item per cycle; each cell holds one multiplier.
// Every cell moves when the cell after it is empty or moving, so a stalled
// receiver fills the row from the back and bubbles are squeezed out; input
// stall rises only once no cell is left free.
// Reset empties the row and loads the register defaults (alpha 98, minimum
// rank increase 256). Configuration is written while no item is in flight.
module link_prr_update_and_rank #(
  parameter int MAX_ATTEMPTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] old_rate_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  attempts_i,
  input  logic [15:0] parent_rank_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] new_rate_o,
  output logic        rate_changed_o,
  output logic [15:0] path_rank_o
);
  import lprr_pkg::*;

  localparam int NDEC = MAX_ATTEMPTS - 1;
  localparam int TW   = $clog2(MAX_ATTEMPTS + 1);
  localparam int NLOSS = 4;

  localparam logic [1:0] CFG_ALPHA    = 2'd0;
  localparam logic [1:0] CFG_MIN_RANK = 2'd1;

  // Configuration registers. Alpha is kept in the two pre-scaled forms that
  // the cells multiply by, so no cell has to divide by one hundred.
  logic [30:0] alpha_k_q;
  logic [46:0] blend_k_q;
  logic [15:0] min_rank_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_k_q      <= alpha_k_f(7'd98);
      blend_k_q      <= blend_k_f(7'd98);
      min_rank_inc_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA: begin
          alpha_k_q <= alpha_k_f(cfg_data_i[6:0]);
          blend_k_q <= blend_k_f(cfg_data_i[6:0]);
        end
        CFG_MIN_RANK: begin
          min_rank_inc_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Entry: attempt counts above the limit count as the limit.
  item_t         in_item;
  logic [TW-1:0] in_tries;

  assign in_item.rate   = old_rate_i;
  assign in_item.status = status_i;
  assign in_item.prank  = parent_rank_i;
  assign in_tries = ({2'b00, attempts_i} > 7'(MAX_ATTEMPTS)) ? TW'(MAX_ATTEMPTS)
                                                             : TW'(attempts_i);

  // Decay cells. Position zero of each array is the input port.
  logic          dec_v   [NDEC+1];
  item_t         dec_item[NDEC+1];
  logic [TW-1:0] dec_tries[NDEC+1];
  logic          dec_rdy [NDEC];

  logic  fin_v, fin_rdy;
  loss_t fin_data;
  logic  loss_v   [NLOSS+1];
  loss_t loss_data[NLOSS+1];
  logic  loss_rdy [NLOSS];
  logic  rank_v, rank_rdy;
  rank_t rank_data;
  logic  out_rdy;

  assign dec_v[0]     = in_valid_i;
  assign dec_item[0]  = in_item;
  assign dec_tries[0] = in_tries;
  assign in_stall_o   = !dec_rdy[0];

  for (genvar j = 0; j < NDEC; j++) begin : g_dec
    if (j == NDEC - 1) begin : g_last
      assign dec_rdy[j] = !dec_v[j+1] || fin_rdy;
    end else begin : g_mid
      assign dec_rdy[j] = !dec_v[j+1] || dec_rdy[j+1];
    end

    lprr_decay_cell #(
      .IDX (j + 1),
      .TW  (TW)
    ) u_dec (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (dec_rdy[j]),
      .valid_i   (dec_v[j]),
      .item_i    (dec_item[j]),
      .tries_i   (dec_tries[j]),
      .alpha_k_i (alpha_k_q),
      .valid_o   (dec_v[j+1]),
      .item_o    (dec_item[j+1]),
      .tries_o   (dec_tries[j+1])
    );
  end

  // The last attempt: another decay on a lost frame, a blend on an ack.
  assign fin_rdy = !fin_v || loss_rdy[0];

  lprr_final_cell u_fin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (fin_rdy),
    .valid_i   (dec_v[NDEC]),
    .item_i    (dec_item[NDEC]),
    .alpha_k_i (alpha_k_q),
    .blend_k_i (blend_k_q),
    .valid_o   (fin_v),
    .data_o    (fin_data)
  );

  // Link loss raised to the fourth power, one step per cell.
  assign loss_v[0]    = fin_v;
  assign loss_data[0] = fin_data;

  for (genvar k = 0; k < NLOSS; k++) begin : g_loss
    if (k == NLOSS - 1) begin : g_last
      assign loss_rdy[k] = !loss_v[k+1] || rank_rdy;
    end else begin : g_mid
      assign loss_rdy[k] = !loss_v[k+1] || loss_rdy[k+1];
    end

    lprr_loss_cell u_loss (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (loss_rdy[k]),
      .valid_i (loss_v[k]),
      .data_i  (loss_data[k]),
      .valid_o (loss_v[k+1]),
      .data_o  (loss_data[k+1])
    );
  end

  // Parent delivery ratio times link delivery ratio, and the rank floor.
  assign rank_rdy = !rank_v || out_rdy;

  lprr_rank_cell u_rank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (rank_rdy),
    .valid_i        (loss_v[NLOSS]),
    .data_i         (loss_data[NLOSS]),
    .min_rank_inc_i (min_rank_inc_q),
    .valid_o        (rank_v),
    .data_o         (rank_data)
  );

  // Output register: round the path delivery ratio, turn it into a loss and
  // take the larger of that and the rank floor.
  logic        out_valid_q;
  logic [15:0] new_rate_q, path_rank_q, path_rank_d;
  logic        changed_q;
  logic [33:0] pdr_sum;
  logic [15:0] path_ratio, path_loss;

  assign out_rdy   = !out_valid_q || !out_stall_i;
  assign pdr_sum   = {1'b0, rank_data.prod} + 34'd32768;
  assign path_ratio = (pdr_sum[33:16] > 18'd65535) ? 16'hFFFF : pdr_sum[31:16];
  assign path_loss = 16'hFFFF - path_ratio;
  assign path_rank_d = (path_loss > rank_data.floor_rank) ? path_loss
                                                          : rank_data.floor_rank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= rank_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && rank_v) begin
      new_rate_q  <= rank_data.rate;
      changed_q   <= rank_data.changed;
      path_rank_q <= path_rank_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_rate_o     = new_rate_q;
  assign rate_changed_o = changed_q;
  assign path_rank_o    = path_rank_q;

endmodule

FILE: rtl/lprr_checker.sv
`include "link_prr_update_and_rank_macros.svh"

module lprr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] new_rate_o,
  input logic        rate_changed_o,
  input logic [15:0] path_rank_o
);

  // The row comes out of reset empty.
  `LPRR_ASSERT_IMP(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), !out_valid_o,
    "item shown right after reset")

  // With nothing waiting at the output every cell is free to take an item.
  `LPRR_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !out_valid_o, !in_stall_o,
    "input stalled while output is empty")

  // A rate of zero delivers nothing, so the path rank is at its maximum.
  `LPRR_ASSERT_IMP(a_zero_rate_rank, clk_i, rst_ni,
    out_valid_o && (new_rate_o == 16'd0), path_rank_o == 16'hFFFF,
    "zero rate without maximum path rank")

  // A stalled result holds.
  `LPRR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(new_rate_o) && $stable(path_rank_o) &&
    $stable(rate_changed_o), "stalled result changed")

endmodule

bind link_prr_update_and_rank lprr_checker u_lprr_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the link reception-rate update and path rank block.
// A queue of pending transmission reports is filled by the stimulus process.
// A clocked driver presents each report, and a clocked monitor checks every
// returned item against the prediction made when its report was accepted.
module tb_top;
  import lprr_pkg::*;

  localparam int          MAX_TRIES      = 16;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 30;
  localparam int          RANDOM_PHASES  = 7;
  localparam int          PHASE_REPORTS  = 100;

  // Register indexes of the configuration port.
  localparam logic [1:0]  REG_DECAY_ALPHA  = 2'd0;
  localparam logic [1:0]  REG_MIN_RANK_INC = 2'd1;

  // Status codes that the package leaves out; both are ignored by the block.
  localparam logic [1:0]  ST_OTHER = 2'd2;
  localparam logic [1:0]  ST_RSVD  = 2'd3;

  localparam logic [31:0] PCT_SCALE   = 32'd100;
  localparam logic [6:0]  ALPHA_LIMIT = 7'd100;
  localparam logic [63:0] LOSS_ONE    = 64'd65536;
  localparam logic [63:0] RATE_FULL   = 64'd65535;
  localparam logic [63:0] ROUND_HALF  = 64'd32768;

  typedef struct packed {
    logic [15:0] old_rate;
    logic [1:0]  status;
    logic [4:0]  attempts;
    logic [15:0] parent_rank;
  } report_t;

  typedef struct packed {
    logic [15:0] new_rate;
    logic        changed;
    logic [15:0] path_rank;
  } update_t;

  // A report together with the idle cycles the sender leaves after it.
  typedef struct {
    report_t     rep;
    int unsigned gap;
  } pending_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = REG_DECAY_ALPHA;
  logic [15:0] cfg_data_i     = 16'd0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [15:0] old_rate_i     = 16'd0;
  logic [1:0]  status_i       = ST_ACK;
  logic [4:0]  attempts_i     = 5'd0;
  logic [15:0] parent_rank_i  = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [15:0] new_rate_o;
  logic        rate_changed_o;
  logic [15:0] path_rank_o;

  link_prr_update_and_rank #(
    .MAX_ATTEMPTS(MAX_TRIES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .old_rate_i    (old_rate_i),
    .status_i      (status_i),
    .attempts_i    (attempts_i),
    .parent_rank_i (parent_rank_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .new_rate_o    (new_rate_o),
    .rate_changed_o(rate_changed_o),
    .path_rank_o   (path_rank_o)
  );

  // The predictor's own copy of the two registers, loaded with the reset values.
  logic [6:0]  alpha_shadow   = 7'd98;
  logic [15:0] min_inc_shadow = 16'd256;

  pending_t    report_q[$];
  update_t     expected_updates_q[$];

  report_t     shown_report;
  pending_t    next_report;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mode_left = 0;
  bit          stall_calm     = 1'b0;
  int unsigned stuck_cycles   = 0;

  int unsigned fail_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned ack_count      = 0;
  int unsigned noack_count    = 0;
  int unsigned other_count    = 0;
  int unsigned settings_count = 1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Works out the item that one report must produce under the given settings.
  // The rate is decayed once per failed attempt, then decayed again or blended
  // toward full reception; the rank follows from the resulting rate.
  function automatic update_t predict_link_update(input report_t r, input logic [6:0] alpha,
                                                  input logic [15:0] min_inc);
    update_t     u;
    logic [31:0] rate;
    logic [31:0] keep;
    int unsigned tries;
    int unsigned i;
    logic [63:0] loss;
    logic [63:0] link_ratio;
    logic [63:0] parent_ratio;
    logic [63:0] path_ratio;
    logic [63:0] path_loss;
    logic [63:0] floor_rank;

    rate  = 32'(r.old_rate);
    keep  = (alpha > ALPHA_LIMIT) ? 32'(ALPHA_LIMIT) : 32'(alpha);
    tries = (r.attempts > MAX_TRIES) ? MAX_TRIES : int'(r.attempts);
    u.changed = (r.status == ST_ACK) || (r.status == ST_NOACK);
    if (u.changed) begin
      for (i = 1; i < tries; i++) begin
        rate = (rate * keep) / PCT_SCALE;
      end
      if (r.status == ST_NOACK) begin
        rate = (rate * keep) / PCT_SCALE;
      end else begin
        rate = (rate * keep + 32'(RATE_FULL) * (PCT_SCALE - keep)) / PCT_SCALE;
      end
      if (rate > 32'(RATE_FULL)) begin
        rate = 32'(RATE_FULL);
      end
    end
    u.new_rate = rate[15:0];

    // Link loss to the fourth power, truncated after every multiply.
    loss = LOSS_ONE;
    for (i = 0; i < 4; i++) begin
      loss = (loss * (LOSS_ONE - 64'(rate))) / LOSS_ONE;
    end
    link_ratio   = (loss > RATE_FULL) ? 64'd0 : RATE_FULL - loss;
    parent_ratio = LOSS_ONE - 64'(r.parent_rank);
    path_ratio   = (ROUND_HALF + parent_ratio * link_ratio) / LOSS_ONE;
    if (path_ratio > RATE_FULL) begin
      path_ratio = RATE_FULL;
    end
    path_loss  = RATE_FULL - path_ratio;
    floor_rank = 64'(r.parent_rank) + 64'(min_inc);
    if (floor_rank > RATE_FULL) begin
      floor_rank = RATE_FULL;
    end
    u.path_rank = (path_loss > floor_rank) ? path_loss[15:0] : floor_rank[15:0];
    return u;
  endfunction

  // Idle cycles: mostly none or a few, now and then a long pause.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Random report, weighted toward the edges of each field.
  function automatic report_t random_report();
    report_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) r.old_rate = 16'd0;
    else if (pick < 20) r.old_rate = 16'hFFFF;
    else if (pick < 35) r.old_rate = 16'($urandom_range(60000, 65535));
    else r.old_rate = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.status = ST_ACK;
    else if (pick < 75) r.status = ST_NOACK;
    else if (pick < 90) r.status = ST_OTHER;
    else r.status = ST_RSVD;
    pick = $urandom_range(0, 99);
    if (pick < 70) r.attempts = 5'($urandom_range(0, MAX_TRIES));
    else if (pick < 90) r.attempts = 5'($urandom_range(MAX_TRIES + 1, 31));
    else r.attempts = (pick < 95) ? 5'd0 : 5'(MAX_TRIES);
    pick = $urandom_range(0, 99);
    if (pick < 15) r.parent_rank = 16'd0;
    else if (pick < 25) r.parent_rank = 16'hFFFF;
    else if (pick < 45) r.parent_rank = 16'($urandom_range(0, 2000));
    else r.parent_rank = 16'($urandom);
    return r;
  endfunction

  task automatic queue_report(input logic [15:0] rate, input logic [1:0] status,
                              input logic [4:0] tries, input logic [15:0] prank);
    pending_t p;
    p.rep = '{old_rate: rate, status: status, attempts: tries, parent_rank: prank};
    p.gap = idle_length();
    report_q.push_back(p);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Blocks until every queued report has gone in and every item has come out.
  task automatic wait_drained();
    while (report_q.size() != 0 || in_valid_i || expected_updates_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Register writes go out one per clock; the shadow copy follows at once,
  // which is safe because nothing is in flight while this runs.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_DECAY_ALPHA) begin
      alpha_shadow = value[6:0];
    end else if (idx == REG_MIN_RANK_INC) begin
      min_inc_shadow = value;
    end
  endtask

  // Driver: when the current report has been taken (or none is shown), it
  // either idles out the gap planned for the last report or shows the next one.
  // Valid and payload only change after acceptance, so a stalled item holds.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_updates_q.push_back(predict_link_update(shown_report, alpha_shadow,
                                                         min_inc_shadow));
        case (shown_report.status)
          ST_ACK:   ack_count++;
          ST_NOACK: noack_count++;
          default:  other_count++;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (report_q.size() > 0) begin
          next_report   = report_q.pop_front();
          shown_report  = next_report.rep;
          gap_left      = next_report.gap;
          old_rate_i    <= next_report.rep.old_rate;
          status_i      <= next_report.rep.status;
          attempts_i    <= next_report.rep.attempts;
          parent_rank_i <= next_report.rep.parent_rank;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted item against the oldest prediction, then
  // chooses the stall for the next cycle. Stalls come in stretches: some
  // stretches never stall, others stall at random for short or long spells.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_updates_q.size() == 0) begin
          note_failure($sformatf("unexpected item: rate %0d changed %0d rank %0d",
                                 new_rate_o, rate_changed_o, path_rank_o));
        end else begin
          update_t want;
          want = expected_updates_q.pop_front();
          checked_count++;
          if (new_rate_o !== want.new_rate || rate_changed_o !== want.changed ||
              path_rank_o !== want.path_rank) begin
            note_failure($sformatf({"item mismatch: expected rate %0d changed %0d rank %0d,",
                                    " got rate %0d changed %0d rank %0d"},
                                   want.new_rate, want.changed, want.path_rank,
                                   new_rate_o, rate_changed_o, path_rank_o));
          end
        end
      end
      if (stall_mode_left == 0) begin
        stall_calm      = ($urandom_range(0, 3) == 0);
        stall_mode_left = $urandom_range(50, 150);
      end else begin
        stall_mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!stall_calm && $urandom_range(0, 99) < 25) begin
        stall_left = idle_length();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: directed reports at the reset settings, then random phases,
  // each under new register values written while the block is empty.
  initial begin
    int unsigned phase;
    int unsigned n;
    bit          quiet;
    logic [6:0]  alpha_val;
    logic [15:0] min_inc_val;
    pending_t    p;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed reports: full and empty rates, every status including the
    // ignored ones, zero and excess attempt counts, and saturating ranks.
    queue_report(16'hFFFF, ST_ACK,   5'd1,  16'd0);
    queue_report(16'd0,    ST_ACK,   5'd1,  16'd0);
    queue_report(16'd0,    ST_NOACK, 5'd1,  16'hFFFF);
    queue_report(16'hFFFF, ST_NOACK, 5'd16, 16'd256);
    queue_report(16'd40000, ST_ACK,   5'd0,  16'd300);
    queue_report(16'd40000, ST_NOACK, 5'd0,  16'd300);
    queue_report(16'd40000, ST_ACK,   5'd17, 16'd300);
    queue_report(16'd40000, ST_NOACK, 5'd31, 16'd300);
    queue_report(16'd12345, ST_OTHER, 5'd5,  16'd1000);
    queue_report(16'd0,    ST_RSVD,  5'd31, 16'hFFFF);
    queue_report(16'hFFFF, ST_OTHER, 5'd0,  16'd0);
    queue_report(16'd0,    ST_OTHER, 5'd3,  16'd0);
    queue_report(16'hFFFF, ST_ACK,   5'd2,  16'hFFFF);
    queue_report(16'd30000, ST_NOACK, 5'd4,  16'd65400);
    queue_report(16'd1,    ST_NOACK, 5'd2,  16'd1);
    queue_report(16'd65534, ST_ACK,   5'd16, 16'd32768);
    queue_report(16'd32768, ST_ACK,   5'd2,  16'd512);
    queue_report(16'h5555, ST_NOACK, 5'd16, 16'hAAAA);
    queue_report(16'hAAAA, ST_ACK,   5'd21, 16'h5555);
    queue_report(16'h5555, ST_NOACK, 5'd10, 16'hAAAA);
    queue_report(16'd1,    ST_RSVD,  5'd1,  16'd65279);
    queue_report(16'hFFFF, ST_RSVD,  5'd16, 16'd65535);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // The sender holds off here until every predicted item has come back.
      wait_drained();
      case (phase)
        0: begin alpha_val = 7'd0;   min_inc_val = 16'd1;     end
        1: begin alpha_val = 7'd100; min_inc_val = 16'hFFFF;  end
        2: begin alpha_val = 7'd127; min_inc_val = 16'd256;   end
        3: begin alpha_val = 7'd1;   min_inc_val = 16'd1024;  end
        4: begin alpha_val = 7'd98;  min_inc_val = 16'd256;   end
        default: begin
          alpha_val   = 7'($urandom_range(0, 127));
          min_inc_val = 16'($urandom_range(1, 65535));
        end
      endcase
      write_reg(REG_DECAY_ALPHA, 16'(alpha_val));
      write_reg(REG_MIN_RANK_INC, min_inc_val);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      settings_count++;
      @(negedge clk_i);

      // Reports go out in runs of 25; about one run in four leaves no gaps.
      quiet = 1'b0;
      for (n = 0; n < PHASE_REPORTS; n++) begin
        if (n % 25 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        p.rep = random_report();
        p.gap = quiet ? 0 : idle_length();
        report_q.push_back(p);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_updates_q.size() != 0) begin
      note_failure($sformatf("%0d predicted items never arrived", expected_updates_q.size()));
    end

    $display("Run covered %0d reports (%0d ack, %0d no-ack, %0d ignored) under %0d settings.",
             ack_count + noack_count + other_count, ack_count, noack_count, other_count,
             settings_count);
    $display("%0d items checked, %0d failures.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
